// ===== src/rzd_pkg.sv =====
package rzd_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    typedef enum logic [1:0] {
        CFG_WINDOW    = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_NOTIFY    = 2'd2
    } cfg_index_t;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] mean_value;
        logic [15:0]        sigma_value;
        logic signed [15:0] z_value;
        logic               extreme_flag;
        logic               crossed;
        logic [31:0]        observation_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_UPDATE,
        ST_MULQ,
        ST_MULS,
        ST_VDIV,
        ST_SQRT,
        ST_MDIV,
        ST_ZPREP,
        ST_ZDIV,
        ST_EMIT
    } be_state_t;

endpackage

// ===== src/rzd_ram.sv =====
module rzd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/rzd_front.sv =====
// Two-entry input queue toward the back end.
module rzd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rzd_pkg::in_item_t in_data,
    output logic             q_valid,
    input  logic             q_take,
    output rzd_pkg::in_item_t q_data
);
    import rzd_pkg::*;

    in_item_t   slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (q_take)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[rd_reg ^ (cnt_reg != 2'd0) ^ (cnt_reg == 2'd2)] <= in_data;
        end
    end
endmodule

// ===== src/rzd_back.sv =====
// Sequencer: ring clear sweep, ring update, variance, square root, mean and z divisions.
module rzd_back #(
    parameter int WINDOW_MAX = rzd_pkg::WINDOW_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_take,
    input  rzd_pkg::in_item_t q_data,
    input  logic [6:0]        window_length,
    input  logic [14:0]       z_limit,
    input  logic              notify_enable,
    output logic              out_valid,
    input  logic              out_stall,
    output rzd_pkg::out_item_t out_data,
    output logic              busy
);
    import rzd_pkg::*;

    localparam int AW  = $clog2(WINDOW_MAX);
    localparam int NW  = $clog2(WINDOW_MAX + 1);
    localparam int SW  = 16 + NW;
    localparam int QW  = 30 + NW;
    localparam int VW  = QW + NW;
    localparam int DW  = 48;

    be_state_t st_reg, st_next;

    logic [AW-1:0]        pos_reg;
    logic [NW-1:0]        fill_reg, win_reg, clr_reg;
    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0]        sq_reg;
    logic                 prev_reg;
    logic [31:0]          cnt_reg;
    logic signed [15:0]   x_reg;
    logic [VW:0]          acc_reg;
    logic [DW-1:0]        rem_reg, quo_reg, div_reg;
    logic [6:0]           step_reg;
    logic [31:0]          root_reg;
    logic [33:0]          srem_reg;
    logic signed [15:0]   mean_reg;
    logic                 zneg_reg;
    out_item_t            res_reg;
    logic                 res_valid_reg;

    logic [15:0] old_q;
    logic        ram_we;
    logic [AW-1:0] ram_wa;
    logic [15:0] ram_wd;

    rzd_ram #(.WIDTH(16), .DEPTH(WINDOW_MAX)) u_ring (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(pos_reg), .rdata(old_q)
    );

    assign ram_we = (st_reg == ST_CLEAR) || (st_reg == ST_UPDATE);
    assign ram_wa = (st_reg == ST_CLEAR) ? clr_reg[AW-1:0] : pos_reg;
    assign ram_wd = (st_reg == ST_CLEAR) ? 16'd0 : x_reg;

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign busy      = (st_reg != ST_IDLE) || res_valid_reg;

    logic [NW-1:0] wl_clamped;
    always_comb
    begin
        if (window_length < 7'd2)
            wl_clamped = NW'(2);
        else if ({25'd0, window_length} > 32'(WINDOW_MAX))
            wl_clamped = NW'(WINDOW_MAX);
        else
            wl_clamped = NW'(window_length);
    end

    // restoring divide step
    logic [DW-1:0] rem_sh;
    logic [DW:0]   rem_sub;
    assign rem_sh  = {rem_reg[DW-2:0], quo_reg[DW-1]};
    assign rem_sub = {1'b0, rem_sh} - {1'b0, div_reg};

    // square root step (two bits per step)
    logic [33:0] sq_trial;
    logic [33:0] sq_rem_sh;
    assign sq_rem_sh = {srem_reg[31:0], quo_reg[DW-1 -: 2]};
    assign sq_trial  = sq_rem_sh - {root_reg, 2'b01};

    logic signed [16:0]   dx;
    assign dx      = 17'(x_reg) - 17'(signed'(old_q));

    logic q_ready;
    assign q_ready = (st_reg == ST_IDLE) && !res_valid_reg;
    assign q_take  = q_ready && q_valid;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:   if (q_take) st_next = (q_data.action == ACT_CLEAR) ? ST_CLEAR : ST_READ;
            ST_CLEAR:  if (clr_reg == NW'(WINDOW_MAX - 1)) st_next = ST_IDLE;
            ST_READ:   st_next = ST_UPDATE;
            ST_UPDATE: st_next = ST_MULQ;
            ST_MULQ:   st_next = ST_MULS;
            ST_MULS:   st_next = ST_VDIV;
            ST_VDIV:   if (step_reg == 7'd0) st_next = ST_SQRT;
            ST_SQRT:   if (step_reg == 7'd0) st_next = ST_MDIV;
            ST_MDIV:   if (step_reg == 7'd0) st_next = ST_ZPREP;
            ST_ZPREP:  st_next = ST_ZDIV;
            ST_ZDIV:   if (step_reg == 7'd0) st_next = ST_EMIT;
            ST_EMIT:   st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    logic [SW-1:0] sabs;
    assign sabs = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    logic signed [SW+1:0] z_num;
    assign z_num = SW'(0) + (SW+2)'($signed({1'b0, fill_reg})) * (SW+2)'(x_reg)
                   - (SW+2)'(sum_reg);

    logic [DW-1:0] zq_abs;
    logic [15:0]   z_sat;
    logic [15:0]   zabs;
    assign zq_abs = quo_reg;
    assign zabs   = (zq_abs > DW'(32767)) ? 16'd32767 : zq_abs[15:0];
    assign z_sat  = zneg_reg ? 16'(-zabs) : zabs;
    logic z_ext;
    assign z_ext = ({1'b0, zabs} >= {2'b0, z_limit});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // ring is swept to zero right after reset
            st_reg        <= ST_CLEAR;
            pos_reg       <= '0;
            fill_reg      <= '0;
            win_reg       <= (WINDOW_MAX < 64) ? NW'(WINDOW_MAX) : NW'(64);
            clr_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            prev_reg      <= 1'b0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (res_valid_reg && !out_stall)
                res_valid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    x_reg <= q_data.sample;
                    if (q_take && q_data.action == ACT_CLEAR)
                    begin
                        clr_reg  <= '0;
                        pos_reg  <= '0;
                        fill_reg <= '0;
                        sum_reg  <= '0;
                        sq_reg   <= '0;
                        prev_reg <= 1'b0;
                        cnt_reg  <= '0;
                        win_reg  <= wl_clamped;
                    end
                end
                ST_CLEAR: clr_reg <= clr_reg + NW'(1);
                ST_READ: ;
                ST_UPDATE:
                begin
                    sum_reg <= sum_reg + SW'(dx);
                    sq_reg  <= sq_reg + QW'($signed(x_reg) * $signed(x_reg))
                               - QW'($signed(old_q) * $signed(old_q));
                    pos_reg <= (NW'(pos_reg) + NW'(1) == win_reg) ? '0 : pos_reg + AW'(1);
                    if (fill_reg != win_reg) fill_reg <= fill_reg + NW'(1);
                    if (cnt_reg != 32'hFFFF_FFFF) cnt_reg <= cnt_reg + 32'd1;
                end
                ST_MULQ:
                    acc_reg <= (VW+1)'(sq_reg) * (VW+1)'(fill_reg);
                ST_MULS:
                begin
                    acc_reg <= (acc_reg > (VW+1)'(sabs) * (VW+1)'(sabs))
                             ? acc_reg - (VW+1)'(sabs) * (VW+1)'(sabs) : '0;
                    div_reg  <= DW'(fill_reg) * DW'(fill_reg);
                    rem_reg  <= '0;
                    step_reg <= 7'(DW);
                end
                ST_VDIV:
                begin
                    if (step_reg == 7'(DW))
                    begin
                        quo_reg  <= DW'(acc_reg);
                        step_reg <= step_reg - 7'd1;
                    end
                    else
                    begin
                        if (!rem_sub[DW])
                        begin
                            rem_reg <= rem_sub[DW-1:0];
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        if (step_reg == 7'd0)
                        begin
                            root_reg <= '0;
                            srem_reg <= '0;
                            step_reg <= 7'(DW / 2);
                        end
                        else
                            step_reg <= step_reg - 7'd1;
                    end
                end
                ST_SQRT:
                begin
                    // DW/2 digit steps, then load the mean divide
                    if (step_reg != 7'd0)
                    begin
                        quo_reg <= {quo_reg[DW-3:0], 2'b00};
                        if (!sq_trial[33] && sq_rem_sh >= {root_reg, 2'b01})
                        begin
                            srem_reg <= sq_trial;
                            root_reg <= {root_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            srem_reg <= sq_rem_sh;
                            root_reg <= {root_reg[30:0], 1'b0};
                        end
                        step_reg <= step_reg - 7'd1;
                    end
                    else
                    begin
                        quo_reg  <= DW'(sabs);
                        rem_reg  <= '0;
                        div_reg  <= DW'(fill_reg);
                        step_reg <= 7'(DW);
                    end
                end
                ST_MDIV:
                begin
                    if (step_reg == 7'(DW))
                    begin
                        res_reg.sigma_value <= (root_reg > 32'hFFFF) ? 16'hFFFF : root_reg[15:0];
                        step_reg <= step_reg - 7'd1;
                    end
                    else
                    begin
                        if (!rem_sub[DW])
                        begin
                            rem_reg <= rem_sub[DW-1:0];
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        step_reg <= step_reg - 7'd1;
                    end
                end
                ST_ZPREP:
                begin
                    mean_reg <= sum_reg[SW-1] ? 16'(-quo_reg) : 16'(quo_reg);
                    zneg_reg <= z_num[SW+1];
                    quo_reg  <= DW'(z_num[SW+1] ? -z_num : z_num) << 8;
                    div_reg  <= DW'(fill_reg) * DW'(res_reg.sigma_value);
                    rem_reg  <= '0;
                    step_reg <= 7'(DW - 1);
                end
                ST_ZDIV:
                begin
                    if (!rem_sub[DW])
                    begin
                        rem_reg <= rem_sub[DW-1:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    if (step_reg != 7'd0) step_reg <= step_reg - 7'd1;
                end
                ST_EMIT:
                begin
                    res_reg.mean_value        <= mean_reg;
                    res_reg.z_value           <= (res_reg.sigma_value == 16'd0) ? 16'd0 : z_sat;
                    res_reg.extreme_flag      <= (res_reg.sigma_value == 16'd0)
                                                 ? (z_limit == 15'd0) : z_ext;
                    res_reg.crossed           <= ((res_reg.sigma_value == 16'd0)
                                                 ? (z_limit == 15'd0) : z_ext)
                                                 && !prev_reg && notify_enable;
                    prev_reg                  <= (res_reg.sigma_value == 16'd0)
                                                 ? (z_limit == 15'd0) : z_ext;
                    res_reg.observation_count <= cnt_reg;
                    res_valid_reg             <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== src/rolling_zscore_detector.sv =====
// Rolling z-score detector. Each beat in carries a signed Q2.14 sample or a
// clear; a sample yields one result beat with the window mean, the floor
// square-root sigma, z in Q8.8 (saturated to +-32767, zero when sigma is
// zero), the extreme flag, a rising-edge crossing pulse gated by
// notify_enable, and a saturating sample count. A front queue of two beats
// takes input while the back sequencer works. After the back end takes a
// beat it reads and updates the ring, forms the two products, runs the
// bit-serial variance divide, the square root and the mean divide, sets up
// and runs the z divide, then emits the result. The back end takes the next
// beat in the cycle after the result is accepted, so it works on one sample
// at a time. A clear sweeps every entry of the sample ring to zero; a new
// window_length takes effect at that clear. The same sweep runs right after
// reset before the first beat is processed.
module rolling_zscore_detector #(
    parameter int WINDOW_MAX = rzd_pkg::WINDOW_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rzd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rzd_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);
    import rzd_pkg::*;

    logic [6:0]  window_length_reg;
    logic [14:0] z_limit_reg;
    logic        notify_enable_reg;

    // config registers; unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= 7'd64;
            z_limit_reg       <= 15'd768;
            notify_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:    window_length_reg <= cfg_data[6:0];
                CFG_THRESHOLD: z_limit_reg       <= cfg_data;
                CFG_NOTIFY:    notify_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic     q_valid, q_take, busy;
    in_item_t q_data;

    rzd_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
    );

    rzd_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
        .window_length(window_length_reg),
        .z_limit(z_limit_reg),
        .notify_enable(notify_enable_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .busy(busy)
    );

    // crossing implies extreme
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.crossed || out_data.extreme_flag))
        else $error("crossed without extreme");

    // no result from an idle back end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result while idle");

    // z saturation bound
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.z_value != 16'h8000))
        else $error("z out of range");
endmodule
